[src/assert_macros.svh]
// Assertion macros for the RTL of the NTC thermistor converter.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");
// Condition must never hold.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

[src/ntc_pkg.sv]
// Shared types and constants of the NTC thermistor converter.
// No dependencies; used by every module of the block.
package ntc_pkg;

    localparam int ADC_BITS_DEF    = 10;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int RAW_W   = 10;
    localparam int VDD_W   = 16;
    localparam int RES_W   = 16;
    localparam int A_W     = 18;
    localparam int TEMP_W  = 16;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 32;
    localparam int LOG_FRAC = 24;
    localparam int LOG_IT_W = 5;

    // ln 2 in Q30, 298.15 K times 100, 273.15 C in Q9.8.
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [14:0] T0_X100   = 15'd29815;
    localparam logic [16:0] ZERO_C_Q8 = 17'd69926;
    // Largest kelvin value that does not saturate high.
    localparam logic [63:0] TK8_MAX   = 64'd102693;

    typedef enum logic [2:0] {
        REG_BETA = 3'd0,
        REG_RS   = 3'd1,
        REG_R0   = 3'd2,
        REG_PAR  = 3'd3,
        REG_RP   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [RES_W-1:0] beta;
        logic [RES_W-1:0] rs;
        logic [RES_W-1:0] r0;
        logic             par;
        logic [RES_W-1:0] rp;
    } cfg_t;

    // One queued sample: supply level and both scaled codes.
    typedef struct packed {
        logic [VDD_W-1:0] vdd;
        logic [A_W-1:0]   a_skin;
        logic [A_W-1:0]   a_amb;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_MUL2,
        S_DENCHK,
        S_LFIND,
        S_LSHIFT,
        S_LSQ,
        S_LACC,
        S_LN,
        S_DMUL,
        S_D,
        S_DIV,
        S_SAT,
        S_NEXT,
        S_DONE
    } state_t;

endpackage

[src/ntc_thermistor_to_celsius.sv]
// NTC thermistor to Celsius converter. Each input transfer carries a supply level and
// two raw ADC codes; one result transfer returns both temperatures in signed Q8.8
// Celsius with a fault flag per channel. The input side scales the codes and places
// the sample in a short queue, so new samples are taken while the engine works. The
// single shared engine converts skin, then ambient; per channel, three log2
// evaluations by repeated squaring and a restoring division dominate the work,
// and a sample takes less time when a channel faults.
// Configuration writes are taken at any time but are meant for idle periods.
// Depends on ntc_pkg, ntc_front, ntc_queue, ntc_back and assert_macros.svh.
`include "assert_macros.svh"

module ntc_thermistor_to_celsius #(
    parameter int ADC_BITS    = ntc_pkg::ADC_BITS_DEF,
    parameter int QUEUE_DEPTH = ntc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // s_tdata: vdd_level[15:0], skin_raw[25:16], ambient_raw[35:26], zero fill
    input  logic [ntc_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // m_tdata: skin_temp[15:0], ambient_temp[31:16]
    output logic [ntc_pkg::OUT_W-1:0] m_tdata,
    // m_tuser: skin_fault[0], ambient_fault[1]
    output logic [1:0]                m_tuser,
    input  logic                      cfg_wr_en,
    input  logic [2:0]                cfg_addr,
    input  logic [15:0]               cfg_wr_data
);

    ntc_pkg::cfg_t    cfg_reg, cfg_next;
    ntc_pkg::q_stat_t q_stat;
    ntc_pkg::item_t   push_item;
    ntc_pkg::item_t   head_item;
    logic             q_push;
    logic             q_pop;

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                ntc_pkg::REG_BETA: cfg_next.beta = cfg_wr_data;
                ntc_pkg::REG_RS:   cfg_next.rs   = cfg_wr_data;
                ntc_pkg::REG_R0:   cfg_next.r0   = cfg_wr_data;
                ntc_pkg::REG_PAR:  cfg_next.par  = cfg_wr_data[0];
                ntc_pkg::REG_RP:   cfg_next.rp   = cfg_wr_data;
                default:           cfg_next      = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.beta <= 16'd4250;
            cfg_reg.rs   <= 16'd1500;
            cfg_reg.r0   <= 16'd10000;
            cfg_reg.par  <= 1'b0;
            cfg_reg.rp   <= 16'd10000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ntc_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    ntc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    ntc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .head_item (head_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // A faulted channel always reports a zero temperature.
    `ASSERT_IMPL(a_skin_fault_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[15:0] == '0)
    `ASSERT_IMPL(a_amb_fault_zero, aclk, aresetn, m_tvalid && m_tuser[1], m_tdata[31:16] == '0)
    // The engine never takes a sample from an empty queue.
    `ASSERT_NEVER(a_pop_empty, aclk, aresetn, q_pop && q_stat.empty)

endmodule

[src/ntc_front.sv]
// Input side: accepts samples and scales both raw codes by the supply level.
// Depends on ntc_pkg.
module ntc_front #(
    parameter int ADC_BITS = ntc_pkg::ADC_BITS_DEF
) (
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // s_tdata: vdd_level[15:0], skin_raw[25:16], ambient_raw[35:26], zero fill
    input  logic [ntc_pkg::IN_W-1:0] s_tdata,
    input  ntc_pkg::q_stat_t         q_stat,
    output logic                     q_push,
    output ntc_pkg::item_t           q_item
);

    localparam int RW = ntc_pkg::RAW_W;
    localparam int PW = RW + ntc_pkg::VDD_W;
    localparam logic [RW-1:0] RAW_MASK =
        (ADC_BITS >= RW) ? {RW{1'b1}} : RW'((1 << ADC_BITS) - 1);

    logic [ntc_pkg::VDD_W-1:0] vdd;
    logic [RW-1:0]             skin_raw;
    logic [RW-1:0]             amb_raw;
    logic [PW-1:0]             skin_prod;
    logic [PW-1:0]             amb_prod;

    // Scale each code to a = code * vdd / 2^ADC_BITS.
    always_comb begin
        vdd       = s_tdata[15:0];
        skin_raw  = s_tdata[25:16] & RAW_MASK;
        amb_raw   = s_tdata[35:26] & RAW_MASK;
        skin_prod = PW'(skin_raw) * PW'(vdd);
        amb_prod  = PW'(amb_raw) * PW'(vdd);
        q_item.vdd    = vdd;
        q_item.a_skin = ntc_pkg::A_W'(skin_prod >> ADC_BITS);
        q_item.a_amb  = ntc_pkg::A_W'(amb_prod >> ADC_BITS);
    end

    // A transfer goes straight into the queue.
    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && !q_stat.full;

endmodule

[src/ntc_queue.sv]
// Short queue that decouples the input side from the conversion engine.
// Depends on ntc_pkg.
module ntc_queue #(
    parameter int DEPTH = ntc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ntc_pkg::item_t   push_item,
    input  logic             pop,
    output ntc_pkg::item_t   head_item,
    output ntc_pkg::q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ntc_pkg::item_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item    = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

[src/ntc_back.sv]
// Conversion engine: divider resistance, iterative log2, beta equation
// division and saturation for both channels, plus the output register.
// Depends on ntc_pkg.
module ntc_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ntc_pkg::cfg_t             cfg,
    input  ntc_pkg::q_stat_t          q_stat,
    input  ntc_pkg::item_t            head_item,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ntc_pkg::OUT_W-1:0] m_tdata,
    output logic [1:0]                m_tuser
);

    localparam logic [ntc_pkg::LOG_IT_W-1:0] LAST_IT =
        ntc_pkg::LOG_IT_W'(ntc_pkg::LOG_FRAC - 1);

    ntc_pkg::state_t state_reg, state_next;

    logic        ch_reg, ch_next;
    logic [15:0] vdd_reg, vdd_next;
    logic [17:0] a_skin_reg, a_skin_next;
    logic [17:0] a_amb_reg, a_amb_next;
    logic [31:0] p1_reg, p1_next;
    logic [31:0] p2_reg, p2_next;
    logic [15:0] diff_reg, diff_next;
    logic [47:0] num_reg, num_next;
    logic signed [32:0] den_reg, den_next;
    logic [1:0]  lsel_reg, lsel_next;
    logic [47:0] lv_reg, lv_next;
    logic [5:0]  p_reg, p_next;
    logic [30:0] m_reg, m_next;
    logic [23:0] frac_reg, frac_next;
    logic [4:0]  it_reg, it_next;
    logic signed [31:0] lq_reg, lq_next;
    logic signed [31:0] lnq_reg, lnq_next;
    logic signed [47:0] tprod_reg, tprod_next;
    logic [30:0] bt_reg, bt_next;
    logic [47:0] d_reg, d_next;
    logic [47:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [15:0] skin_temp_reg, skin_temp_next;
    logic [15:0] amb_temp_reg, amb_temp_next;
    logic        skin_fault_reg, skin_fault_next;
    logic        amb_fault_reg, amb_fault_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    // Shared conditions.
    logic [17:0] a_cur;
    logic        setup_fault;
    logic        den_fault;
    logic        d_fault;
    logic        out_free;
    logic signed [49:0] dfull;
    logic [22:0] beta100;
    logic signed [49:0] tprod_ext;

    // Datapath temporaries.
    logic [15:0] diff_c;
    logic [47:0] vl;
    logic [61:0] sq;
    logic [31:0] m2;
    logic signed [31:0] lacc_l;
    logic [31:0] lq_abs;
    logic [63:0] lnprod;
    logic [31:0] lnmag;
    logic signed [15:0] t0_s;
    logic [48:0] rem_sh;
    logic        div_ge;
    logic signed [17:0] tv;
    logic [15:0] temp_sat;
    logic        ch_fault;
    logic        ch_write;
    logic [15:0] ch_temp;

    // Fault and handshake conditions.
    always_comb begin
        a_cur       = ch_reg ? a_amb_reg : a_skin_reg;
        setup_fault = (a_cur == '0) || (a_cur >= {2'b00, vdd_reg}) ||
                      (cfg.rs == '0) || (cfg.r0 == '0) ||
                      (cfg.par && (cfg.rp == '0));
        den_fault   = den_reg[32] || (den_reg == '0);
        beta100     = 23'(cfg.beta) * 23'd100;
        tprod_ext   = {{2{tprod_reg[47]}}, tprod_reg};
        dfull       = $signed({3'b000, beta100, 24'b0}) - tprod_ext;
        d_fault     = dfull[49] || (dfull == '0);
        out_free    = !m_tvalid_reg || m_tready;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ntc_pkg::S_IDLE:   if (!q_stat.empty) state_next = ntc_pkg::S_SETUP;
            ntc_pkg::S_SETUP:  state_next = setup_fault ? ntc_pkg::S_NEXT : ntc_pkg::S_MUL2;
            ntc_pkg::S_MUL2:   state_next = ntc_pkg::S_DENCHK;
            ntc_pkg::S_DENCHK: state_next = den_fault ? ntc_pkg::S_NEXT : ntc_pkg::S_LFIND;
            ntc_pkg::S_LFIND:  state_next = ntc_pkg::S_LSHIFT;
            ntc_pkg::S_LSHIFT: state_next = ntc_pkg::S_LSQ;
            ntc_pkg::S_LSQ:    if (it_reg == LAST_IT) state_next = ntc_pkg::S_LACC;
            ntc_pkg::S_LACC:   state_next = (lsel_reg == 2'd2) ? ntc_pkg::S_LN : ntc_pkg::S_LFIND;
            ntc_pkg::S_LN:     state_next = ntc_pkg::S_DMUL;
            ntc_pkg::S_DMUL:   state_next = ntc_pkg::S_D;
            ntc_pkg::S_D:      state_next = d_fault ? ntc_pkg::S_NEXT : ntc_pkg::S_DIV;
            ntc_pkg::S_DIV:    if (cnt_reg == 6'd63) state_next = ntc_pkg::S_SAT;
            ntc_pkg::S_SAT:    state_next = ntc_pkg::S_NEXT;
            ntc_pkg::S_NEXT:   state_next = ch_reg ? ntc_pkg::S_DONE : ntc_pkg::S_SETUP;
            ntc_pkg::S_DONE:   if (out_free) state_next = ntc_pkg::S_IDLE;
            default:           state_next = ntc_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs of each state.
    always_comb begin
        ch_next       = ch_reg;
        vdd_next      = vdd_reg;
        a_skin_next   = a_skin_reg;
        a_amb_next    = a_amb_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        diff_next     = diff_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        lsel_next     = lsel_reg;
        lv_next       = lv_reg;
        p_next        = p_reg;
        m_next        = m_reg;
        frac_next     = frac_reg;
        it_next       = it_reg;
        lq_next       = lq_reg;
        lnq_next      = lnq_reg;
        tprod_next    = tprod_reg;
        bt_next       = bt_reg;
        d_next        = d_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        skin_temp_next  = skin_temp_reg;
        amb_temp_next   = amb_temp_reg;
        skin_fault_next = skin_fault_reg;
        amb_fault_next  = amb_fault_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        q_pop         = 1'b0;
        ch_fault      = 1'b0;
        ch_write      = 1'b0;
        ch_temp       = '0;

        diff_c = vdd_reg - a_cur[15:0];
        vl     = lv_reg << (6'd47 - p_reg);
        sq     = {31'b0, m_reg} * {31'b0, m_reg};
        m2     = sq[61:30];
        lacc_l = $signed({2'b00, p_reg, frac_reg});
        lq_abs = lq_reg[31] ? 32'(-lq_reg) : 32'(lq_reg);
        lnprod = {32'b0, lq_abs} * {34'b0, ntc_pkg::LN2_Q30} + 64'h2000_0000;
        lnmag  = lnprod[61:30];
        t0_s   = $signed({1'b0, ntc_pkg::T0_X100});
        rem_sh = {rem_reg, quo_reg[63]};
        div_ge = rem_sh >= {1'b0, d_reg};
        tv     = $signed({1'b0, quo_reg[16:0]}) - $signed({1'b0, ntc_pkg::ZERO_C_Q8});
        if (quo_reg > ntc_pkg::TK8_MAX) begin
            temp_sat = 16'h7FFF;
        end else if (tv < -18'sd32768) begin
            temp_sat = 16'h8000;
        end else begin
            temp_sat = tv[15:0];
        end

        case (state_reg)
            ntc_pkg::S_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop       = 1'b1;
                    vdd_next    = head_item.vdd;
                    a_skin_next = head_item.a_skin;
                    a_amb_next  = head_item.a_amb;
                    ch_next     = 1'b0;
                end
            end
            ntc_pkg::S_SETUP: begin
                // First divider products.
                p1_next   = 32'(a_cur[15:0]) * 32'(cfg.rs);
                p2_next   = 32'(diff_c) * 32'(cfg.rp);
                diff_next = diff_c;
                if (setup_fault) begin
                    ch_write = 1'b1;
                    ch_fault = 1'b1;
                end
            end
            ntc_pkg::S_MUL2: begin
                // Resistance as a ratio num / den.
                if (cfg.par) begin
                    num_next = 48'(p1_reg) * 48'(cfg.rp);
                    den_next = $signed({1'b0, p2_reg}) - $signed({1'b0, p1_reg});
                end else begin
                    num_next = {16'b0, p1_reg};
                    den_next = $signed({17'b0, diff_reg});
                end
            end
            ntc_pkg::S_DENCHK: begin
                lv_next   = {32'b0, cfg.r0};
                lsel_next = 2'd0;
                if (den_fault) begin
                    ch_write = 1'b1;
                    ch_fault = 1'b1;
                end
            end
            ntc_pkg::S_LFIND: begin
                // Position of the leading one.
                p_next = '0;
                for (int i = 0; i < 48; i++) begin
                    if (lv_reg[i]) p_next = 6'(i);
                end
            end
            ntc_pkg::S_LSHIFT: begin
                m_next    = vl[47:17];
                frac_next = '0;
                it_next   = '0;
            end
            ntc_pkg::S_LSQ: begin
                // One fraction bit per squaring.
                frac_next = {frac_reg[22:0], m2[31]};
                m_next    = m2[31] ? m2[31:1] : m2[30:0];
                it_next   = it_reg + 1'b1;
            end
            ntc_pkg::S_LACC: begin
                case (lsel_reg)
                    2'd0: begin
                        lq_next   = lacc_l;
                        lv_next   = {16'b0, den_reg[31:0]};
                        lsel_next = 2'd1;
                    end
                    2'd1: begin
                        lq_next   = lq_reg + lacc_l;
                        lv_next   = num_reg;
                        lsel_next = 2'd2;
                    end
                    default: begin
                        lq_next = lq_reg - lacc_l;
                    end
                endcase
            end
            ntc_pkg::S_LN: begin
                lnq_next = lq_reg[31] ? -$signed(lnmag) : $signed(lnmag);
            end
            ntc_pkg::S_DMUL: begin
                tprod_next = lnq_reg * t0_s;
                bt_next    = 31'(cfg.beta) * 31'(ntc_pkg::T0_X100);
            end
            ntc_pkg::S_D: begin
                d_next   = dfull[47:0];
                quo_next = {1'b0, bt_reg, 32'b0} + {16'b0, dfull[48:1]};
                rem_next = '0;
                cnt_next = '0;
                if (d_fault) begin
                    ch_write = 1'b1;
                    ch_fault = 1'b1;
                end
            end
            ntc_pkg::S_DIV: begin
                // Restoring division, one quotient bit per cycle.
                rem_next = div_ge ? 48'(rem_sh - {1'b0, d_reg}) : rem_sh[47:0];
                quo_next = {quo_reg[62:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            ntc_pkg::S_SAT: begin
                ch_write = 1'b1;
                ch_temp  = temp_sat;
            end
            ntc_pkg::S_NEXT: begin
                ch_next = 1'b1;
            end
            ntc_pkg::S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {amb_temp_reg, skin_temp_reg};
                    m_tuser_next  = {amb_fault_reg, skin_fault_reg};
                end
            end
            default: begin
                ch_next = 1'b0;
            end
        endcase

        // Channel result write; a fault leaves a zero temperature.
        if (ch_write) begin
            if (ch_reg) begin
                amb_temp_next  = ch_temp;
                amb_fault_next = ch_fault;
            end else begin
                skin_temp_next  = ch_temp;
                skin_fault_next = ch_fault;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ntc_pkg::S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        ch_reg          <= ch_next;
        vdd_reg         <= vdd_next;
        a_skin_reg      <= a_skin_next;
        a_amb_reg       <= a_amb_next;
        p1_reg          <= p1_next;
        p2_reg          <= p2_next;
        diff_reg        <= diff_next;
        num_reg         <= num_next;
        den_reg         <= den_next;
        lsel_reg        <= lsel_next;
        lv_reg          <= lv_next;
        p_reg           <= p_next;
        m_reg           <= m_next;
        frac_reg        <= frac_next;
        it_reg          <= it_next;
        lq_reg          <= lq_next;
        lnq_reg         <= lnq_next;
        tprod_reg       <= tprod_next;
        bt_reg          <= bt_next;
        d_reg           <= d_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        cnt_reg         <= cnt_next;
        skin_temp_reg   <= skin_temp_next;
        amb_temp_reg    <= amb_temp_next;
        skin_fault_reg  <= skin_fault_next;
        amb_fault_reg   <= amb_fault_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the NTC thermistor to Celsius converter.
// Depends on ntc_pkg and ntc_thermistor_to_celsius; a fixed-point predictor checks each result.
`timescale 1ns / 1ps

module testbench;

    localparam logic [2:0] REG_UNUSED_LO = 3'd5;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;
    localparam int         DRAIN_CYCLES  = 400;
    localparam int         STALL_LIMIT   = 20000;
    localparam longint     ZERO_C        = 69926;

    typedef struct {
        logic [15:0] skin_temp;
        logic [15:0] amb_temp;
        logic        skin_fault;
        logic        amb_fault;
    } temps_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [ntc_pkg::IN_W-1:0]     s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [ntc_pkg::OUT_W-1:0]    m_tdata;
    logic [1:0]                   m_tuser;
    logic                         cfg_wr_en;
    logic [2:0]                   cfg_addr;
    logic [15:0]                  cfg_wr_data;

    // Predictor copy of the registers.
    logic [15:0] beta_q;
    logic [15:0] rs_q;
    logic [15:0] r0_q;
    logic        par_q;
    logic [15:0] rp_q;

    temps_t pending_temps[$];
    int     errors = 0;
    int     stall_count = 0;
    int     send_idle_pct;
    int     recv_idle_pct;

    ntc_thermistor_to_celsius dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // log2 in Q24 by repeated squaring of the normalized mantissa.
    function automatic longint log2_q24(longint unsigned v);
        int p;
        longint unsigned m;
        longint frac;
        p = 63;
        frac = 0;
        while (p > 0 && v[p] == 1'b0) p--;
        if (p >= 30) m = v >> (p - 30);
        else m = v << (30 - p);
        for (int i = 0; i < ntc_pkg::LOG_FRAC; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return longint'(p) * (longint'(1) << ntc_pkg::LOG_FRAC) + frac;
    endfunction

    // One channel: returns the fault bit, temperature through temp.
    function automatic logic celsius_of(logic [15:0] vdd, logic [9:0] raw,
                                        output logic [15:0] temp);
        longint unsigned a, num_r, mag;
        longint den_r, lq, lnq, d, t;
        temp = 16'd0;
        a = (longint'(raw) * longint'(vdd)) >> 10;
        if (a == 0 || a >= vdd || rs_q == 0 || r0_q == 0) return 1'b1;
        if (par_q) begin
            if (rp_q == 0) return 1'b1;
            num_r = a * rs_q * rp_q;
            den_r = longint'(vdd - a) * longint'(rp_q) - longint'(a) * longint'(rs_q);
        end else begin
            num_r = a * rs_q;
            den_r = longint'(vdd) - longint'(a);
        end
        if (den_r <= 0) return 1'b1;
        lq = log2_q24(r0_q) + log2_q24(den_r) - log2_q24(num_r);
        mag = (lq < 0) ? -lq : lq;
        mag = (mag * 64'd744261118 + (64'd1 << 29)) >> 30;
        lnq = (lq < 0) ? -longint'(mag) : longint'(mag);
        d = longint'(100 * longint'(beta_q)) * (longint'(1) << ntc_pkg::LOG_FRAC)
            - 29815 * lnq;
        if (d <= 0) return 1'b1;
        mag = (longint'(beta_q) * 64'd29815) << 32;
        mag = (mag + longint'(d / 2)) / longint'(d);
        if (mag > 32767 + ZERO_C) t = 32767;
        else begin
            t = longint'(mag) - ZERO_C;
            if (t < -32768) t = -32768;
        end
        temp = t[15:0];
        return 1'b0;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            ntc_pkg::REG_BETA: beta_q = val;
            ntc_pkg::REG_RS:   rs_q = val;
            ntc_pkg::REG_R0:   r0_q = val;
            ntc_pkg::REG_PAR:  par_q = val[0];
            ntc_pkg::REG_RP:   rp_q = val;
            default: ;
        endcase
    endtask

    task automatic set_all(logic [15:0] b, logic [15:0] rs, logic [15:0] r0,
                           logic par, logic [15:0] rp);
        write_reg(ntc_pkg::REG_BETA, b);
        write_reg(ntc_pkg::REG_RS, rs);
        write_reg(ntc_pkg::REG_R0, r0);
        write_reg(ntc_pkg::REG_PAR, {15'd0, par});
        write_reg(ntc_pkg::REG_RP, rp);
    endtask

    // Send one sample, record its expected temperatures on acceptance.
    task automatic send_sample(logic [15:0] vdd, logic [9:0] skin, logic [9:0] amb);
        temps_t exp_t;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, amb, skin, vdd};
        do @(posedge aclk); while (!s_tready);
        exp_t.skin_fault = celsius_of(vdd, skin, exp_t.skin_temp);
        exp_t.amb_fault  = celsius_of(vdd, amb, exp_t.amb_temp);
        pending_temps.push_back(exp_t);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    // Wait until every result is back and the engine has gone quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_temps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_default_regs();
        send_sample(16'd3300, 10'd512, 10'd300);
        send_sample(16'hFFFF, 10'd1023, 10'd1);
        send_sample(16'd0, 10'd512, 10'd100);
        send_sample(16'd3300, 10'd0, 10'd1023);
        send_sample(16'd1, 10'd1023, 10'd0);
        send_sample(16'd2, 10'd512, 10'd1023);
        send_sample(16'hFFFF, 10'd0, 10'h2AA);
        send_sample(16'h5555, 10'h155, 10'h3FF);
        drain();
    endtask

    task automatic test_parallel_extremes();
        set_all(16'hFFFF, 16'd1, 16'hFFFF, 1'b1, 16'd1);
        send_sample(16'hFFFF, 10'd512, 10'd1);
        send_sample(16'd3300, 10'd1, 10'd1022);
        drain();
        set_all(16'd3950, 16'd10000, 16'd10000, 1'b1, 16'd20000);
        send_sample(16'd3300, 10'd400, 10'd900);
        send_sample(16'hFFFF, 10'd100, 10'd700);
        drain();
        // A tiny beta drives the beta denominator to zero or below for some channels.
        set_all(16'd1, 16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF);
        send_sample(16'd3300, 10'd5, 10'd1000);
        send_sample(16'hFFFF, 10'd1, 10'd512);
        drain();
        // Zero resistor registers fault every channel; unused indexes are ignored.
        set_all(16'd4250, 16'd0, 16'd10000, 1'b1, 16'd0);
        write_reg(REG_UNUSED_LO, 16'hFFFF);
        write_reg(REG_UNUSED_HI, 16'h1234);
        send_sample(16'd3300, 10'd512, 10'd200);
        drain();
        write_reg(ntc_pkg::REG_RS, 16'd1500);
        send_sample(16'd3300, 10'd512, 10'd200);
        drain();
        write_reg(ntc_pkg::REG_RP, 16'd10000);
        write_reg(ntc_pkg::REG_R0, 16'd0);
        send_sample(16'd3300, 10'd512, 10'd200);
        drain();
    endtask

    task automatic test_random(int n_items);
        logic [15:0] vdd;
        logic [9:0]  skin, amb;
        for (int i = 0; i < n_items; i++) begin
            case ($urandom_range(3))
                0: vdd = 16'($urandom);
                1: vdd = 16'($urandom_range(3600, 2800));
                2: vdd = 16'($urandom_range(65535, 60000));
                default: vdd = 16'($urandom_range(20));
            endcase
            skin = ($urandom_range(15) == 0) ? {10{1'($urandom_range(1))}} : 10'($urandom);
            amb  = ($urandom_range(15) == 0) ? {10{1'($urandom_range(1))}} : 10'($urandom);
            send_sample(vdd, skin, amb);
        end
        drain();
    endtask

    // Random register setting, leaning to realistic parts and sometimes extremes.
    task automatic random_regs();
        logic [15:0] b, rs, r0, rp;
        b  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4500, 3000));
        rs = ($urandom_range(3) == 0) ? 16'($urandom_range(65535, 1))
                                      : 16'($urandom_range(20000, 500));
        r0 = ($urandom_range(3) == 0) ? 16'($urandom_range(65535, 1))
                                      : 16'($urandom_range(50000, 2000));
        rp = ($urandom_range(3) == 0) ? 16'($urandom_range(65535, 1))
                                      : 16'($urandom_range(60000, 5000));
        set_all(b, rs, r0, 1'($urandom_range(1)), rp);
    endtask

    // Receiver: random stall and check of each result transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_temps.size() == 0) begin
                    $display("%0t: unexpected result %h/%b", $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    temps_t e;
                    e = pending_temps.pop_front();
                    if (m_tdata[15:0] !== e.skin_temp || m_tdata[31:16] !== e.amb_temp
                        || m_tuser[0] !== e.skin_fault || m_tuser[1] !== e.amb_fault) begin
                        $display("%0t: expected skin %h amb %h faults %b%b, got %h %h %b",
                                 $time, e.skin_temp, e.amb_temp, e.amb_fault,
                                 e.skin_fault, m_tdata[15:0], m_tdata[31:16], m_tuser);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_count <= 0;
        else stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wr_data   = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        beta_q = 16'd4250;
        rs_q   = 16'd1500;
        r0_q   = 16'd10000;
        par_q  = 1'b0;
        rp_q   = 16'd10000;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_regs();
        test_parallel_extremes();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 71; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 71; end
                default: begin send_idle_pct = 25; recv_idle_pct = 25; end
            endcase
            random_regs();
            test_random(200);
        end

        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
